// ===== hw/rtl/i2r_pkg.sv =====
// Shared types and the Roman numeral symbol table for the integer to Roman numeral unit.
`timescale 1ns / 1ps

package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 7;
    localparam int ENTRIES  = 13;
    localparam int IDX_W    = $clog2(ENTRIES);

    localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;

    typedef struct packed {
        logic [VALUE_W-1:0]  amount;
        logic [SYMBOL_W-1:0] first;
        logic [SYMBOL_W-1:0] second;
        logic                pair;
    } i2r_entry_t;

    // Greedy table, largest amount first; subtractive forms are two-symbol entries.
    localparam i2r_entry_t RN_TABLE [ENTRIES] = '{
        '{12'd1000, SYM_M, SYM_M, 1'b0},
        '{12'd900,  SYM_C, SYM_M, 1'b1},
        '{12'd500,  SYM_D, SYM_D, 1'b0},
        '{12'd400,  SYM_C, SYM_D, 1'b1},
        '{12'd100,  SYM_C, SYM_C, 1'b0},
        '{12'd90,   SYM_X, SYM_C, 1'b1},
        '{12'd50,   SYM_L, SYM_L, 1'b0},
        '{12'd40,   SYM_X, SYM_L, 1'b1},
        '{12'd10,   SYM_X, SYM_X, 1'b0},
        '{12'd9,    SYM_I, SYM_X, 1'b1},
        '{12'd5,    SYM_V, SYM_V, 1'b0},
        '{12'd4,    SYM_I, SYM_V, 1'b1},
        '{12'd1,    SYM_I, SYM_I, 1'b0}
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } i2r_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } i2r_cmd_t;

    typedef struct packed {
        logic value_zero;
        logic final_char;
    } i2r_status_t;

    // Index of the largest table amount not above rem; rem must be nonzero.
    function automatic logic [IDX_W-1:0] pick_entry(input logic [VALUE_W-1:0] rem);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(ENTRIES - 1);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (rem >= RN_TABLE[i].amount)
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/i2r_ctrl.sv =====
// Controller state machine for the integer to Roman numeral unit.
`timescale 1ns / 1ps

module i2r_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  i2r_pkg::i2r_status_t status,
    output i2r_pkg::i2r_cmd_t   cmd,
    output logic                busy
);

    i2r_pkg::i2r_state_t state_reg;
    i2r_pkg::i2r_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2r_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            i2r_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    // zero converts to nothing: stay idle
                    if (!status.value_zero)
                    begin
                        state_next = i2r_pkg::ST_RUN;
                    end
                end
            end
            i2r_pkg::ST_RUN:
            begin
                busy     = 1'b1;
                cmd.step = 1'b1;
                if (status.final_char)
                begin
                    state_next = i2r_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2r_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/i2r_datapath.sv =====
// Datapath: remainder register, greedy symbol selection and registered result outputs.
`timescale 1ns / 1ps

module i2r_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [i2r_pkg::VALUE_W-1:0]         value,
    input  i2r_pkg::i2r_cmd_t                   cmd,
    output i2r_pkg::i2r_status_t                status,
    output logic                                strobe,
    output logic [i2r_pkg::SYMBOL_W-1:0]        symbol,
    output logic                                last
);

    logic [i2r_pkg::VALUE_W-1:0]  rem_reg;
    logic [i2r_pkg::VALUE_W-1:0]  rem_next;
    logic                         second_reg;
    logic                         second_next;
    logic                         strobe_reg;
    logic                         strobe_next;
    logic [i2r_pkg::SYMBOL_W-1:0] symbol_reg;
    logic [i2r_pkg::SYMBOL_W-1:0] symbol_next;
    logic                         last_reg;
    logic                         last_next;
    logic [i2r_pkg::IDX_W-1:0]    idx;
    i2r_pkg::i2r_entry_t          entry;
    logic                         is_first_of_pair;

    assign idx              = i2r_pkg::pick_entry(rem_reg);
    assign entry            = i2r_pkg::RN_TABLE[idx];
    assign is_first_of_pair = entry.pair && !second_reg;

    assign status.value_zero = (value == '0);
    assign status.final_char = !is_first_of_pair && (rem_reg == entry.amount);

    always_comb
    begin
        rem_next    = rem_reg;
        second_next = second_reg;
        strobe_next = 1'b0;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        if (cmd.load)
        begin
            rem_next    = value;
            second_next = 1'b0;
        end
        else if (cmd.step)
        begin
            strobe_next = 1'b1;
            if (is_first_of_pair)
            begin
                symbol_next = entry.first;
                last_next   = 1'b0;
                second_next = 1'b1;
            end
            else
            begin
                symbol_next = entry.pair ? entry.second : entry.first;
                last_next   = status.final_char;
                rem_next    = rem_reg - entry.amount;
                second_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
    end

    assign strobe = strobe_reg;
    assign symbol = symbol_reg;
    assign last   = last_reg;

endmodule

// ===== hw/rtl/integer_to_roman_numeral_unit.sv =====
// Top level of the integer to Roman numeral unit: controller plus datapath.
// Start loads the value into the remainder register; the controller then runs and registers each character.
// A new value is taken only in idle; numerals are 0 to 15 characters; zero gives no characters.
// One character is chosen per cycle by the greedy table lookup on the remainder register.
// Reset (rst_n, async, active low) returns the controller to idle and clears the strobe.
// The receiver cannot stall: each character is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module integer_to_roman_numeral_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [i2r_pkg::VALUE_W-1:0]  value,
    output logic                         busy,
    output logic                         strobe,
    output logic [i2r_pkg::SYMBOL_W-1:0] symbol,
    output logic                         last
);

    i2r_pkg::i2r_cmd_t    cmd;
    i2r_pkg::i2r_status_t status;

    i2r_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    i2r_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .symbol (symbol),
        .last   (last)
    );

endmodule
